/* rtl/smt_pkg.sv */
package smt_pkg;

    localparam int DATA_W       = 32;
    localparam int CMD_W        = 3;
    localparam int STATUS_W     = 2;
    localparam int MATCH_W      = 5;
    localparam int MATCH_MAX    = 31;
    localparam int CAPACITY_DEF = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT    = 3'd0,
        CMD_REMOVE    = 3'd1,
        CMD_COUNT     = 3'd2,
        CMD_READ_ASC  = 3'd3,
        CMD_READ_DESC = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_SCAN,
        S_READ,
        S_DONE
    } t_state;

    typedef struct packed {
        logic eq;
        logic lt;
    } t_cmp;

    typedef struct packed {
        t_status             status;
        logic [DATA_W-1:0]   value;
        logic [MATCH_W-1:0]  count;
        logic                last;
    } t_res;

endpackage

/* rtl/smt_mem.sv */
module smt_mem #(
    parameter int DEPTH = smt_pkg::CAPACITY_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [smt_pkg::DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]             i_raddr,
    output logic [smt_pkg::DATA_W-1:0] o_rdata
);

    logic [smt_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [smt_pkg::DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/smt_alu.sv */
module smt_alu (
    input  logic [smt_pkg::DATA_W-1:0] i_a,
    input  logic [smt_pkg::DATA_W-1:0] i_b,
    output smt_pkg::t_cmp             o_cmp
);

    // signed order of the stored entry against the operand
    always_comb begin
        o_cmp.eq = (i_a == i_b);
        o_cmp.lt = ($signed(i_a) < $signed(i_b));
    end

endmodule

/* rtl/smt_ctrl.sv */
module smt_ctrl #(
    parameter int CAPACITY = smt_pkg::CAPACITY_DEF,
    parameter int AW       = $clog2(CAPACITY),
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [smt_pkg::CMD_W-1:0]  i_command,
    input  logic [smt_pkg::DATA_W-1:0] i_operand_value,
    input  logic                       i_out_free,
    output logic                       o_load,
    output smt_pkg::t_res              o_res,
    output logic [AW-1:0]              o_raddr,
    input  logic [smt_pkg::DATA_W-1:0] i_rdata,
    output logic                       o_we,
    output logic [AW-1:0]              o_waddr,
    output logic [smt_pkg::DATA_W-1:0] o_wdata,
    output logic [smt_pkg::DATA_W-1:0] o_operand,
    input  smt_pkg::t_cmp              i_cmp
);

    localparam int SW = (CW > smt_pkg::MATCH_W) ? CW : smt_pkg::MATCH_W;

    smt_pkg::t_state            r_state, n_state;
    smt_pkg::t_cmd              r_cmd, n_cmd;
    logic [smt_pkg::DATA_W-1:0] r_operand, n_operand;
    logic [CW-1:0]              r_fill, n_fill;
    logic [AW-1:0]              r_rd_idx, n_rd_idx;
    logic [CW-1:0]              r_ptr, n_ptr;
    logic [CW-1:0]              r_left, n_left;
    logic [CW-1:0]              r_hits, n_hits;
    smt_pkg::t_res              r_pend, n_pend;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            smt_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_command) inside
                        smt_pkg::CMD_INSERT: begin
                            n_state = (r_fill == CW'(CAPACITY)) ? smt_pkg::S_DONE
                                                                : smt_pkg::S_INS;
                        end
                        smt_pkg::CMD_REMOVE, smt_pkg::CMD_COUNT: begin
                            n_state = (r_fill == '0) ? smt_pkg::S_DONE : smt_pkg::S_SCAN;
                        end
                        smt_pkg::CMD_READ_ASC, smt_pkg::CMD_READ_DESC: begin
                            n_state = (r_fill == '0) ? smt_pkg::S_DONE : smt_pkg::S_READ;
                        end
                        default: n_state = smt_pkg::S_IDLE;
                    endcase
                end
            end
            smt_pkg::S_INS: begin
                if (r_ptr == '0 || i_cmp.lt) begin
                    n_state = smt_pkg::S_DONE;
                end
            end
            smt_pkg::S_SCAN: begin
                if (r_left == CW'(1)) begin
                    n_state = smt_pkg::S_DONE;
                end
            end
            smt_pkg::S_READ: begin
                if (i_out_free && r_left == CW'(1)) begin
                    n_state = smt_pkg::S_IDLE;
                end
            end
            smt_pkg::S_DONE: begin
                if (i_out_free) begin
                    n_state = smt_pkg::S_IDLE;
                end
            end
            default: n_state = smt_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        logic [SW-1:0]               hits_x;
        logic [smt_pkg::MATCH_W-1:0] hits_sat;
        logic                        is_remove;

        n_cmd     = r_cmd;
        n_operand = r_operand;
        n_fill    = r_fill;
        n_rd_idx  = r_rd_idx;
        n_ptr     = r_ptr;
        n_left    = r_left;
        n_hits    = r_hits;
        n_pend    = r_pend;
        o_we      = 1'b0;
        o_waddr   = r_ptr[AW-1:0];
        o_wdata   = i_rdata;
        o_load    = 1'b0;
        o_res     = r_pend;
        is_remove = (r_cmd == smt_pkg::CMD_REMOVE);
        hits_x    = '0;
        hits_sat  = '0;

        unique case (r_state)
            smt_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd     = smt_pkg::t_cmd'(i_command);
                    n_operand = i_operand_value;
                    n_ptr     = '0;
                    n_hits    = '0;
                    n_left    = r_fill;
                    unique case (i_command) inside
                        smt_pkg::CMD_INSERT: begin
                            // fill from the top slot downwards
                            n_ptr    = r_fill;
                            n_rd_idx = AW'(r_fill - CW'(1));
                            n_pend   = '{status: (r_fill == CW'(CAPACITY)) ? smt_pkg::ST_FULL
                                                                          : smt_pkg::ST_OK,
                                         value: '0, count: '0, last: 1'b1};
                        end
                        smt_pkg::CMD_REMOVE, smt_pkg::CMD_COUNT: begin
                            n_rd_idx = '0;
                            n_pend   = '{status: (i_command == smt_pkg::CMD_REMOVE)
                                                 ? smt_pkg::ST_NOTFOUND : smt_pkg::ST_OK,
                                         value: '0, count: '0, last: 1'b1};
                        end
                        smt_pkg::CMD_READ_ASC: begin
                            n_rd_idx = '0;
                            n_pend   = '{status: smt_pkg::ST_EMPTY, value: '0, count: '0,
                                         last: 1'b1};
                        end
                        smt_pkg::CMD_READ_DESC: begin
                            n_rd_idx = AW'(r_fill - CW'(1));
                            n_pend   = '{status: smt_pkg::ST_EMPTY, value: '0, count: '0,
                                         last: 1'b1};
                        end
                        default: n_cmd = r_cmd;
                    endcase
                end
            end
            smt_pkg::S_INS: begin
                o_we    = 1'b1;
                o_waddr = r_ptr[AW-1:0];
                if (r_ptr == '0 || i_cmp.lt) begin
                    o_wdata = r_operand;
                    n_fill  = r_fill + CW'(1);
                end else begin
                    // entry not below the operand moves up one slot
                    o_wdata  = i_rdata;
                    n_ptr    = r_ptr - CW'(1);
                    n_rd_idx = AW'(r_ptr - CW'(2));
                end
            end
            smt_pkg::S_SCAN: begin
                if (is_remove && !i_cmp.eq) begin
                    o_we    = 1'b1;
                    o_waddr = r_ptr[AW-1:0];
                    n_ptr   = r_ptr + CW'(1);
                end
                if (i_cmp.eq) begin
                    n_hits = r_hits + CW'(1);
                end
                n_left   = r_left - CW'(1);
                n_rd_idx = r_rd_idx + AW'(1);
                hits_x   = SW'(n_hits);
                hits_sat = (hits_x > SW'(smt_pkg::MATCH_MAX))
                         ? smt_pkg::MATCH_W'(smt_pkg::MATCH_MAX)
                         : smt_pkg::MATCH_W'(hits_x);
                if (r_left == CW'(1)) begin
                    if (is_remove) begin
                        n_fill = n_ptr;
                    end
                    n_pend = '{status: (is_remove && n_hits == '0) ? smt_pkg::ST_NOTFOUND
                                                                   : smt_pkg::ST_OK,
                               value: '0, count: hits_sat, last: 1'b1};
                end
            end
            smt_pkg::S_READ: begin
                if (i_out_free) begin
                    o_load   = 1'b1;
                    o_res    = '{status: smt_pkg::ST_OK, value: i_rdata, count: '0,
                                 last: (r_left == CW'(1))};
                    n_left   = r_left - CW'(1);
                    n_rd_idx = (r_cmd == smt_pkg::CMD_READ_DESC) ? r_rd_idx - AW'(1)
                                                                  : r_rd_idx + AW'(1);
                end
            end
            smt_pkg::S_DONE: begin
                if (i_out_free) begin
                    o_load = 1'b1;
                end
            end
            default: n_cmd = r_cmd;
        endcase
    end

    assign o_in_ready = (r_state == smt_pkg::S_IDLE);
    // address presented now, so the registered read data matches r_rd_idx
    assign o_raddr    = n_rd_idx;
    assign o_operand  = r_operand;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= smt_pkg::S_IDLE;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_operand <= n_operand;
        r_rd_idx  <= n_rd_idx;
        r_ptr     <= n_ptr;
        r_left    <= n_left;
        r_hits    <= n_hits;
        r_pend    <= n_pend;
    end

endmodule

/* rtl/sorted_multiset_table_unit.sv */
// sequence: insert shifts each entry not below the operand up one slot, then writes it,
//   remove and count scan every stored entry, and reads give one entry per cycle
//   while the output is taken
// throughput: one command at a time through the single table read port and comparator;
//   the next command is taken the cycle after the last result enters the output register
// reset: synchronous active low, empties the table at once; table contents are not cleared
module sorted_multiset_table_unit #(
    parameter int CAPACITY = smt_pkg::CAPACITY_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [smt_pkg::CMD_W-1:0]         i_command,
    input  logic signed [smt_pkg::DATA_W-1:0] i_operand_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [smt_pkg::STATUS_W-1:0]      o_status,
    output logic signed [smt_pkg::DATA_W-1:0] o_entry_value,
    output logic [smt_pkg::MATCH_W-1:0]       o_match_count,
    output logic                              o_last
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic                       out_free;
    logic                       load;
    smt_pkg::t_res              res;
    logic [AW-1:0]              raddr;
    logic [smt_pkg::DATA_W-1:0] rdata;
    logic                       we;
    logic [AW-1:0]              waddr;
    logic [smt_pkg::DATA_W-1:0] wdata;
    logic [smt_pkg::DATA_W-1:0] operand;
    smt_pkg::t_cmp              cmp;

    logic                       r_out_valid;
    smt_pkg::t_res              r_out;

    smt_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_command       (i_command),
        .i_operand_value (i_operand_value),
        .i_out_free      (out_free),
        .o_load          (load),
        .o_res           (res),
        .o_raddr         (raddr),
        .i_rdata         (rdata),
        .o_we            (we),
        .o_waddr         (waddr),
        .o_wdata         (wdata),
        .o_operand       (operand),
        .i_cmp           (cmp)
    );

    smt_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    smt_alu u_alu (
        .i_a   (rdata),
        .i_b   (operand),
        .o_cmp (cmp)
    );

    // output register parts the sequencer from the result channel
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out.status;
    assign o_entry_value = r_out.value;
    assign o_match_count = r_out.count;
    assign o_last        = r_out.last;

endmodule

/* rtl/smt_checker.sv */
module smt_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_ready,
    input logic [smt_pkg::CMD_W-1:0]         i_command,
    input logic signed [smt_pkg::DATA_W-1:0] i_operand_value,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic [smt_pkg::STATUS_W-1:0]      o_status,
    input logic signed [smt_pkg::DATA_W-1:0] o_entry_value,
    input logic [smt_pkg::MATCH_W-1:0]       o_match_count,
    input logic                              o_last
);

    // a stalled item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_entry_value) && $stable(o_match_count) && $stable(o_last))
        else $error("result item changed while stalled");

    // only a read entry can be followed by more items of the same run
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != smt_pkg::ST_OK |-> o_last)
        else $error("error status item not marked last");

    a_full_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == smt_pkg::ST_FULL || o_status == smt_pkg::ST_EMPTY)
            |-> o_entry_value == '0 && o_match_count == '0)
        else $error("full or empty item carries data");

    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == smt_pkg::ST_NOTFOUND |-> o_match_count == '0)
        else $error("remove found nothing but reports a count");

    // every known command drops ready in the cycle after it is taken
    a_busy_after_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_command <= smt_pkg::CMD_READ_DESC |=> !o_in_ready)
        else $error("ready right after a command was taken");

endmodule

bind sorted_multiset_table_unit smt_checker u_smt_checker (.*);

/* verif/sorted_table_checker.sv */
module sorted_table_checker
    import smt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  logic [CMD_W-1:0]          i_command,
    input  logic signed [DATA_W-1:0]  i_operand_value,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic [STATUS_W-1:0]       i_status,
    input  logic signed [DATA_W-1:0]  i_entry_value,
    input  logic [MATCH_W-1:0]        i_match_count,
    input  logic                      i_last,
    output int                        o_errors,
    output int                        o_pending,
    output int                        o_checked,
    output int                        o_full_rejects,
    output int                        o_empty_reads
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    // shadow copy of the sorted store, ascending in slots below shadow_fill
    logic signed [DATA_W-1:0] shadow_entries [CAPACITY];
    int                       shadow_fill  = 0;
    t_res                     results_due [$];
    int                       mismatches   = 0;
    int                       checked      = 0;
    int                       full_rejects = 0;
    int                       empty_reads  = 0;

    assign o_errors       = mismatches;
    assign o_checked      = checked;
    assign o_full_rejects = full_rejects;
    assign o_empty_reads  = empty_reads;

    function automatic t_res make_result(t_status st, logic [DATA_W-1:0] val, int hits,
                                         logic fin);
        t_res r;
        r.status = st;
        r.value  = val;
        r.count  = (hits > MATCH_MAX) ? MATCH_W'(MATCH_MAX) : MATCH_W'(hits);
        r.last   = fin;
        return r;
    endfunction

    function automatic void note_mismatch(string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endfunction

    task automatic predict_table_op(input logic [CMD_W-1:0] cmd,
                                    input logic signed [DATA_W-1:0] val);
        int      pos;
        int      kept;
        int      hits;
        int      slot;
        t_status st;
        case (cmd)
            CMD_INSERT: begin
                if (shadow_fill >= CAPACITY) begin
                    results_due.push_back(make_result(ST_FULL, '0, 0, 1'b1));
                    full_rejects++;
                end else begin
                    // new value goes after every smaller entry, so ahead of equal ones
                    pos = 0;
                    while (pos < shadow_fill && shadow_entries[pos] < val) pos++;
                    for (int k = shadow_fill; k > pos; k--) begin
                        shadow_entries[k] = shadow_entries[k-1];
                    end
                    shadow_entries[pos] = val;
                    shadow_fill++;
                    results_due.push_back(make_result(ST_OK, '0, 0, 1'b1));
                end
            end
            CMD_REMOVE: begin
                kept = 0;
                for (int k = 0; k < shadow_fill; k++) begin
                    if (shadow_entries[k] != val) begin
                        shadow_entries[kept] = shadow_entries[k];
                        kept++;
                    end
                end
                hits = shadow_fill - kept;
                if (hits == 0) st = ST_NOTFOUND;
                else st = ST_OK;
                results_due.push_back(make_result(st, '0, hits, 1'b1));
                shadow_fill = kept;
            end
            CMD_COUNT: begin
                hits = 0;
                for (int k = 0; k < shadow_fill; k++) begin
                    if (shadow_entries[k] == val) hits++;
                end
                results_due.push_back(make_result(ST_OK, '0, hits, 1'b1));
            end
            CMD_READ_ASC, CMD_READ_DESC: begin
                if (shadow_fill == 0) begin
                    results_due.push_back(make_result(ST_EMPTY, '0, 0, 1'b1));
                    empty_reads++;
                end else begin
                    for (int k = 0; k < shadow_fill; k++) begin
                        if (cmd == CMD_READ_ASC) slot = k;
                        else slot = shadow_fill - 1 - k;
                        results_due.push_back(make_result(ST_OK, shadow_entries[slot], 0,
                                                          k == shadow_fill - 1));
                    end
                end
            end
            default: ; // unused codes leave the store alone and give nothing back
        endcase
    endtask

    task automatic compare_result();
        t_res due;
        checked++;
        if (results_due.size() == 0) begin
            note_mismatch($sformatf("result with nothing outstanding: status %0d value %0d count %0d last %0b",
                                    i_status, i_entry_value, i_match_count, i_last));
            return;
        end
        due = results_due.pop_front();
        if (i_status !== due.status || i_entry_value !== due.value
                || i_match_count !== due.count || i_last !== due.last) begin
            note_mismatch($sformatf({"expected status %0d value %0d count %0d last %0b, ",
                                     "got status %0d value %0d count %0d last %0b"},
                                    due.status, $signed(due.value), due.count, due.last,
                                    i_status, i_entry_value, i_match_count, i_last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_fill = 0;
            results_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) compare_result();
            if (i_in_valid && i_in_ready) predict_table_op(i_command, i_operand_value);
        end
        o_pending = results_due.size();
    end

endmodule

/* verif/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import smt_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 80;
    localparam int SETTLE_CYCLES  = CAPACITY_DEF + 20;
    localparam int POOL_SIZE      = 8;
    localparam int RECENT_MAX     = 32;

    localparam logic [CMD_W-1:0]  CMD_UNUSED_LO = 3'd5;
    localparam logic [CMD_W-1:0]  CMD_UNUSED_HI = 3'd7;
    localparam logic [DATA_W-1:0] VAL_MIN       = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] VAL_MAX       = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] VAL_NEG_ONE   = '1;
    localparam logic [DATA_W-1:0] VAL_ZERO      = '0;

    logic                      i_clk           = 1'b0;
    logic                      i_rst_n         = 1'b0;
    logic                      i_in_valid      = 1'b0;
    logic                      o_in_ready;
    logic [CMD_W-1:0]          i_command       = '0;
    logic signed [DATA_W-1:0]  i_operand_value = '0;
    logic                      o_out_valid;
    logic                      i_out_ready     = 1'b0;
    logic [STATUS_W-1:0]       o_status;
    logic signed [DATA_W-1:0]  o_entry_value;
    logic [MATCH_W-1:0]        o_match_count;
    logic                      o_last;

    int error_count;
    int results_pending;
    int results_checked;
    int full_rejects;
    int empty_reads;

    bit          tx_idle_en   = 1'b1;
    bit          rx_idle_en   = 1'b1;
    bit          hold_req     = 1'b0;
    bit          hold_done    = 1'b0;
    int          hold_left    = 0;
    int          gap_left     = 0;
    int          quiet_cycles = 0;
    int          items_sent   = 0;
    logic [DATA_W-1:0] value_pool [POOL_SIZE];
    logic [DATA_W-1:0] inserted_q [$];

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    sorted_multiset_table_unit #(
        .CAPACITY        (CAPACITY_DEF)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_command       (i_command),
        .i_operand_value (i_operand_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_entry_value   (o_entry_value),
        .o_match_count   (o_match_count),
        .o_last          (o_last)
    );

    sorted_table_checker #(
        .CAPACITY        (CAPACITY_DEF)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_command       (i_command),
        .i_operand_value (i_operand_value),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_status        (o_status),
        .i_entry_value   (o_entry_value),
        .i_match_count   (o_match_count),
        .i_last          (o_last),
        .o_errors        (error_count),
        .o_pending       (results_pending),
        .o_checked       (results_checked),
        .o_full_rejects  (full_rejects),
        .o_empty_reads   (empty_reads)
    );

    // result side: short random stalls, plus one long hold to back the block up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            i_out_ready <= 1'b0;
        end else if (gap_left > 0) begin
            gap_left--;
            i_out_ready <= 1'b0;
        end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
            gap_left = $urandom_range(0, 3);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
                     quiet_cycles, results_pending);
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] val);
        i_in_valid      <= 1'b1;
        i_command       <= cmd;
        i_operand_value <= val;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic send_insert(input logic [DATA_W-1:0] val);
        send_item(CMD_INSERT, val);
        inserted_q.push_back(val);
        if (inserted_q.size() > RECENT_MAX) void'(inserted_q.pop_front());
    endtask

    // mostly values that repeat, so that counts and removes find several copies
    function automatic logic [DATA_W-1:0] pick_insert_value();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll < 5) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (roll < 7 && inserted_q.size() > 0)
            return inserted_q[$urandom_range(0, inserted_q.size() - 1)];
        return $urandom();
    endfunction

    function automatic logic [DATA_W-1:0] pick_lookup_value();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll < 5 && inserted_q.size() > 0)
            return inserted_q[$urandom_range(0, inserted_q.size() - 1)];
        if (roll < 8) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom();
    endfunction

    task automatic run_random(input int count);
        int unsigned roll;
        repeat (count) begin
            roll = $urandom_range(0, 19);
            if (roll < 8) send_insert(pick_insert_value());
            else if (roll < 11 || roll == 19) send_item(CMD_REMOVE, pick_lookup_value());
            else if (roll < 14) send_item(CMD_COUNT, pick_lookup_value());
            else if (roll < 16) send_item(CMD_READ_ASC, $urandom());
            else if (roll < 18) send_item(CMD_READ_DESC, $urandom());
            else send_item(CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)), $urandom());
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (results_pending != 0) @(posedge i_clk);
    endtask

    initial begin
        value_pool[0] = VAL_MIN;
        value_pool[1] = VAL_MAX;
        value_pool[2] = VAL_ZERO;
        value_pool[3] = VAL_NEG_ONE;
        value_pool[4] = 32'sd1;
        for (int k = 5; k < POOL_SIZE; k++) value_pool[k] = $urandom();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty store: reads, a remove that finds nothing, a count of zero
        send_item(CMD_READ_ASC, VAL_ZERO);
        send_item(CMD_READ_DESC, VAL_NEG_ONE);
        send_item(CMD_REMOVE, 32'sd5);
        send_item(CMD_COUNT, VAL_ZERO);
        // extremes and a duplicate
        send_insert(VAL_MAX);
        send_insert(VAL_MIN);
        send_insert(VAL_ZERO);
        send_insert(VAL_NEG_ONE);
        send_insert(VAL_ZERO);
        send_item(CMD_COUNT, VAL_ZERO);
        send_item(CMD_COUNT, VAL_MIN);
        send_item(CMD_READ_ASC, $urandom());
        send_item(CMD_READ_DESC, $urandom());
        send_item(CMD_REMOVE, VAL_ZERO);
        send_item(CMD_REMOVE, 32'sd7);
        send_item(CMD_UNUSED_LO, VAL_MAX);
        send_item(CMD_UNUSED_LO + 3'd1, VAL_MIN);
        send_item(CMD_UNUSED_HI, $urandom());
        wait_drained();

        // fill past capacity so the last inserts are refused, then full-length reads
        repeat (CAPACITY_DEF + 2) send_insert(pick_insert_value());
        send_item(CMD_READ_DESC, $urandom());
        send_item(CMD_READ_ASC, $urandom());

        // hold the result side while reads keep coming, so the input stalls
        hold_req <= 1'b1;
        repeat (3) send_item(CMD_READ_ASC, $urandom());

        // empty it again value by value
        foreach (inserted_q[k]) send_item(CMD_REMOVE, inserted_q[k]);
        inserted_q.delete();
        send_item(CMD_READ_DESC, $urandom());
        send_item(CMD_COUNT, VAL_MAX);
        wait_drained();

        run_random(170);
        wait_drained();

        // a stretch with no stalls on either side
        tx_idle_en <= 1'b0;
        rx_idle_en <= 1'b0;
        run_random(110);

        tx_idle_en <= 1'b1;
        rx_idle_en <= 1'b1;
        run_random(80);
        wait_drained();

        tx_idle_en <= 1'b0;
        rx_idle_en <= 1'b0;
        run_random(40);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("sent %0d commands, checked %0d results against the shadow store",
                 items_sent, results_checked);
        $display("inserts refused on a full store: %0d, reads of an empty store: %0d",
                 full_rejects, empty_reads);
        if (error_count == 0 && results_pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
